### design/pse_pkg.sv
// Shared types and codes for the postfix stack evaluator.
`timescale 1ns / 1ps
package pse_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned StatW  = 2;
  localparam int unsigned DepthW = 7;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_SUB  = 3'd2,
    CMD_MUL  = 3'd3,
    CMD_DIV  = 3'd4,
    CMD_NEG  = 3'd5
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_e;

  // What one stack cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_TAKE_UP   = 2'd1,
    CELL_TAKE_DOWN = 2'd2
  } cell_op_e;

endpackage

### design/pse_cell.sv
// One stack entry: holds its word or takes the word of a neighbour.
`timescale 1ns / 1ps
module pse_cell
  import pse_pkg::*;
(
  input  logic             clk_i,
  input  cell_op_e         op_i,
  input  logic [DataW-1:0] up_i,
  input  logic [DataW-1:0] down_i,
  output logic [DataW-1:0] data_o
);

  logic [DataW-1:0] data_q, data_d;

  always_comb begin
    case (op_i)
      CELL_TAKE_UP:   data_d = up_i;
      CELL_TAKE_DOWN: data_d = down_i;
      default:        data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### design/pse_div.sv
// Signed 32-bit divider, truncating, one quotient bit per cycle.
`timescale 1ns / 1ps
module pse_div
  import pse_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] dividend_i,
  input  logic [DataW-1:0] divisor_i,
  output logic             done_o,
  output logic [DataW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DataW);

  typedef enum logic {
    D_IDLE,
    D_RUN
  } dstate_e;

  dstate_e          state_q;
  logic [CntW-1:0]  cnt_q;
  logic             done_q;
  logic             neg_q;
  logic [DataW-1:0] rem_q, quo_q, den_q;

  logic [DataW:0]   rem_shift, diff;

  assign rem_shift = {rem_q, quo_q[DataW-1]};
  assign diff      = rem_shift - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        D_IDLE: begin
          if (start_i) begin
            state_q <= D_RUN;
            cnt_q   <= '0;
          end
        end
        D_RUN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(DataW - 1)) begin
            state_q <= D_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  // Magnitudes are taken on start; the sign is restored on the way out
  always_ff @(posedge clk_i) begin
    if (state_q == D_IDLE && start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i[DataW-1] ? (DataW'(0) - dividend_i) : dividend_i;
      den_q <= divisor_i[DataW-1] ? (DataW'(0) - divisor_i) : divisor_i;
      neg_q <= dividend_i[DataW-1] ^ divisor_i[DataW-1];
    end else if (state_q == D_RUN) begin
      if (!diff[DataW]) begin
        rem_q <= diff[DataW-1:0];
        quo_q <= {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_q <= rem_shift[DataW-1:0];
        quo_q <= {quo_q[DataW-2:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (DataW'(0) - quo_q) : quo_q;

endmodule

### design/postfix_stack_evaluator_core.sv
// Top level of the postfix stack evaluator: control, arithmetic and the cell row.
`timescale 1ns / 1ps
// An item is taken when start is high and busy is low. Push, add, subtract,
// negate, unused commands and every faulting step finish in the EXEC state,
// multiply goes on through the WB state, and divide waits in the DIV state
// for the divider, which produces one quotient bit per cycle. The result is on
// the output ports for one cycle with valid_o high and cannot be held off, so
// it must be taken then. busy falls in that same cycle, so the next item may
// be started while the result is shown. The stack is a row of shift cells:
// the top entry sits in the first cell, and push and pop move every entry one
// place in a single cycle. Stack_depth_o gives the entry count masked to 7 bits.
module postfix_stack_evaluator_core
  import pse_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [CmdW-1:0]          command_i,
  input  logic signed [DataW-1:0]  operand_value_i,
  output logic                     valid_o,
  output logic [StatW-1:0]         status_o,
  output logic signed [DataW-1:0]  top_value_o,
  output logic [DepthW-1:0]        stack_depth_o
);

  localparam int unsigned SpW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_WB
  } state_e;

  state_e           state_q, state_d;
  logic [SpW-1:0]   sp_q, sp_d;
  logic             valid_q;
  logic [StatW-1:0] status_q;
  logic [DataW-1:0] top_q;

  logic [CmdW-1:0]  cmd_q;
  logic [DataW-1:0] val_q;
  logic [DataW-1:0] res_q, res_d;

  logic [DataW-1:0] cell_data [STACK_DEPTH];
  cell_op_e         top_op, rest_op;
  logic [DataW-1:0] top_new;
  logic             fin;
  status_e          stat;
  logic             div_start, div_done;
  logic [DataW-1:0] div_quot;
  logic [DataW-1:0] t_val, s_val;
  logic [DataW-1:0] prod;
  logic [SpW+DepthW-1:0] sp_ext;

  assign t_val = cell_data[0];
  assign s_val = cell_data[1];
  // only the low word of the product is kept
  assign prod  = t_val * s_val;

  always_comb begin
    state_d   = state_q;
    sp_d      = sp_q;
    res_d     = res_q;
    top_op    = CELL_HOLD;
    rest_op   = CELL_HOLD;
    top_new   = t_val;
    fin       = 1'b0;
    stat      = ST_OK;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) state_d = S_EXEC;
      end
      S_EXEC: begin
        fin = 1'b1;
        case (cmd_q)
          CMD_PUSH: begin
            if (sp_q == SpW'(STACK_DEPTH)) begin
              stat = ST_OVER;
            end else begin
              top_new = val_q;
              top_op  = CELL_TAKE_UP;
              rest_op = CELL_TAKE_UP;
              sp_d    = sp_q + 1'b1;
            end
          end
          CMD_NEG: begin
            if (sp_q == '0) begin
              stat = ST_UNDER;
            end else begin
              top_new = DataW'(0) - t_val;
              top_op  = CELL_TAKE_UP;
            end
          end
          CMD_ADD, CMD_SUB: begin
            if (sp_q < SpW'(2)) begin
              stat = ST_UNDER;
            end else begin
              top_new = (cmd_q == CMD_ADD) ? (s_val + t_val) : (s_val - t_val);
              top_op  = CELL_TAKE_UP;
              rest_op = CELL_TAKE_DOWN;
              sp_d    = sp_q - 1'b1;
            end
          end
          CMD_MUL: begin
            if (sp_q < SpW'(2)) begin
              stat = ST_UNDER;
            end else begin
              fin     = 1'b0;
              res_d   = prod;
              state_d = S_WB;
            end
          end
          CMD_DIV: begin
            if (sp_q < SpW'(2)) begin
              stat = ST_UNDER;
            end else if (t_val == '0) begin
              stat = ST_DIVZ;
            end else begin
              fin       = 1'b0;
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
          default: ;
        endcase
        if (fin) state_d = S_IDLE;
      end
      S_DIV: begin
        if (div_done) begin
          res_d   = div_quot;
          state_d = S_WB;
        end
      end
      S_WB: begin
        // replace the top pair by the result
        fin     = 1'b1;
        top_new = res_q;
        top_op  = CELL_TAKE_UP;
        rest_op = CELL_TAKE_DOWN;
        sp_d    = sp_q - 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      sp_q     <= '0;
      valid_q  <= 1'b0;
      status_q <= ST_OK;
      top_q    <= '0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      valid_q <= fin;
      if (fin) begin
        status_q <= stat;
        top_q    <= (sp_d == '0) ? '0 : top_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      cmd_q <= command_i;
      val_q <= operand_value_i;
    end
    res_q <= res_d;
  end

  pse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (s_val),
    .divisor_i  (t_val),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DataW-1:0] up_w, down_w;
    if (i == 0) begin : g_first
      assign up_w = top_new;
    end else begin : g_mid
      assign up_w = cell_data[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign down_w = '0;
    end else begin : g_inner
      assign down_w = cell_data[i+1];
    end
    pse_cell u_cell (
      .clk_i  (clk_i),
      .op_i   ((i == 0) ? top_op : rest_op),
      .up_i   (up_w),
      .down_i (down_w),
      .data_o (cell_data[i])
    );
  end

  assign sp_ext        = {{DepthW{1'b0}}, sp_q};
  assign busy          = (state_q != S_IDLE);
  assign valid_o       = valid_q;
  assign status_o      = status_q;
  assign top_value_o   = top_q;
  assign stack_depth_o = sp_ext[DepthW-1:0];

endmodule

### verif/pse_result_checker.sv
// Result checker for the postfix stack evaluator: predicts each result and compares it.
`timescale 1ns / 1ps
module pse_result_checker
  import pse_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned MaxReports  = 60
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  input  logic                    busy,
  input  logic [CmdW-1:0]         command,
  input  logic [DataW-1:0]        operand_value,
  input  logic                    result_valid,
  input  logic [StatW-1:0]        status,
  input  logic [DataW-1:0]        top_value,
  input  logic [DepthW-1:0]       stack_depth,
  output int                      fail_count_o,
  output int                      pending_o
);

  typedef struct packed {
    status_e           status;
    logic [DataW-1:0]  top;
    logic [DepthW-1:0] depth;
  } eval_result_t;

  logic [DataW-1:0] operand_stack [STACK_DEPTH];
  int unsigned      entries;
  eval_result_t     expected_results [$];
  eval_result_t     want;
  int               errors;

  // Signed division truncated toward zero; the most negative over -1 wraps to itself
  function automatic logic [DataW-1:0] quotient_trunc(logic [DataW-1:0] num,
                                                      logic [DataW-1:0] den);
    logic [DataW-1:0] num_mag;
    logic [DataW-1:0] den_mag;
    logic [DataW-1:0] quo;
    num_mag = num[DataW-1] ? -num : num;
    den_mag = den[DataW-1] ? -den : den;
    quo     = num_mag / den_mag;
    return (num[DataW-1] ^ den[DataW-1]) ? -quo : quo;
  endfunction

  // Apply one token to the shadow stack and return the result it must give
  function automatic eval_result_t eval_token(logic [CmdW-1:0] cmd, logic [DataW-1:0] val);
    eval_result_t     res;
    logic [DataW-1:0] top_op;
    logic [DataW-1:0] second_op;
    logic [DataW-1:0] value;
    res.status = ST_OK;
    case (cmd)
      CMD_PUSH: begin
        if (entries >= STACK_DEPTH) begin
          res.status = ST_OVER;
        end else begin
          operand_stack[entries] = val;
          entries++;
        end
      end
      CMD_NEG: begin
        if (entries < 1) res.status = ST_UNDER;
        else operand_stack[entries-1] = -operand_stack[entries-1];
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
        if (entries < 2) begin
          res.status = ST_UNDER;
        end else begin
          top_op    = operand_stack[entries-1];
          second_op = operand_stack[entries-2];
          if (cmd == CMD_DIV && top_op == '0) begin
            res.status = ST_DIVZ;
          end else begin
            case (cmd)
              CMD_ADD: value = second_op + top_op;
              CMD_SUB: value = second_op - top_op;
              CMD_MUL: value = second_op * top_op;
              default: value = quotient_trunc(second_op, top_op);
            endcase
            operand_stack[entries-2] = value;
            entries--;
          end
        end
      end
      default: ;  // spare codes leave everything as it is
    endcase
    res.top   = (entries > 0) ? operand_stack[entries-1] : '0;
    res.depth = entries[DepthW-1:0];
    return res;
  endfunction

  task automatic check_field(string field, logic [DataW-1:0] exp_v, logic [DataW-1:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      if (errors <= MaxReports)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries = 0;
      expected_results.delete();
      errors = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      // compare first: a result shown in a transfer cycle belongs to an earlier token
      if (result_valid) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= MaxReports)
            $display("%0t: unexpected result, expected none, got status %0d top %0h depth %0d",
                     $time, status, top_value, stack_depth);
        end else begin
          want = expected_results.pop_front();
          check_field("status", DataW'(want.status), DataW'(status));
          check_field("top_value", want.top, top_value);
          check_field("stack_depth", DataW'(want.depth), DataW'(stack_depth));
        end
      end
      if (start && !busy) expected_results.push_back(eval_token(command, operand_value));
      fail_count_o <= errors;
      pending_o <= expected_results.size();
    end
  end

endmodule

### verif/postfix_stack_evaluator_core_tb.sv
// Testbench top for the postfix stack evaluator: token stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module postfix_stack_evaluator_core_tb
  import pse_pkg::*;
();

  localparam int unsigned ResetCycles   = 11;
  localparam int unsigned RandomItems   = 1300;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned DrainCycles   = 60;
  localparam int unsigned DirectedItems = 24;

  // codes the block treats as no operation
  localparam logic [CmdW-1:0] CmdSpareA = 3'd6;
  localparam logic [CmdW-1:0] CmdSpareB = 3'd7;

  localparam logic [CmdW-1:0] Operators [5] = '{CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_NEG};

  localparam logic [DataW-1:0] Filler = 32'hA5A5_5A5A;

  localparam logic [CmdW-1:0] DirCmd [DirectedItems] = '{
    CMD_ADD, CMD_NEG, CMD_DIV, CMD_PUSH, CMD_SUB, CMD_PUSH, CMD_ADD, CMD_NEG,
    CMD_PUSH, CMD_DIV, CMD_PUSH, CMD_DIV, CmdSpareA, CmdSpareB, CMD_MUL, CMD_PUSH,
    CMD_PUSH, CMD_DIV, CMD_SUB, CMD_PUSH, CMD_MUL, CMD_PUSH, CMD_ADD, CMD_NEG
  };
  localparam logic [DataW-1:0] DirVal [DirectedItems] = '{
    Filler, Filler, Filler, 32'h7FFF_FFFF, Filler, 32'h0000_0001, 32'h5A5A_A5A5, Filler,
    32'hFFFF_FFFF, Filler, 32'h0000_0000, Filler, Filler, Filler, 32'hFFFF_FFFF,
    32'hFFFF_FFF9, 32'h0000_0002, Filler, Filler, 32'h8000_0000, Filler,
    32'h1234_5678, Filler, Filler
  };

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [CmdW-1:0]         command = '0;
  logic [DataW-1:0]        operand_value = '0;
  logic                    valid_o;
  logic [StatW-1:0]        status_o;
  logic signed [DataW-1:0] top_value_o;
  logic [DepthW-1:0]       stack_depth_o;

  int          fail_count;
  int          pending;
  int unsigned quiet_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned phase_left = 0;
  bit          filling = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  postfix_stack_evaluator_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .command_i       (command),
    .operand_value_i (operand_value),
    .valid_o         (valid_o),
    .status_o        (status_o),
    .top_value_o     (top_value_o),
    .stack_depth_o   (stack_depth_o)
  );

  pse_result_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .operand_value (operand_value),
    .result_valid  (valid_o),
    .status        (status_o),
    .top_value     (top_value_o),
    .stack_depth   (stack_depth_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // End the run when neither side has made a transfer for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold start high until the token is taken
  task automatic send_token(input logic [CmdW-1:0] cmd, input logic [DataW-1:0] val);
    @(negedge clk_i);
    start <= 1'b1;
    command <= cmd;
    operand_value <= val;
    do @(posedge clk_i); while (busy);
  endtask

  // Insert a random gap once the current burst is used up
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
    end
    burst_left--;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [DataW-1:0] pick_operand();
    logic [DataW-1:0] val;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: val = $urandom();
      4, 5, 6:    val = DataW'($signed($urandom_range(0, 8)) - 4);
      7: begin
        case ($urandom_range(0, 4))
          0:       val = 32'h8000_0000;
          1:       val = 32'h7FFF_FFFF;
          2:       val = 32'hFFFF_FFFF;
          3:       val = 32'h0000_0001;
          default: val = '0;
        endcase
      end
      8:       val = 32'd1 << $urandom_range(0, 31);
      default: val = DataW'($signed(16'($urandom())));
    endcase
    return val;
  endfunction

  // Fill phases mostly push so the stack reaches overflow; drain phases mostly
  // apply operators so it runs down to underflow
  function automatic logic [CmdW-1:0] pick_command(bit fill);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < (fill ? 85 : 15)) return CMD_PUSH;
    if (roll < (fill ? 88 : 19)) return $urandom_range(0, 1) ? CmdSpareA : CmdSpareB;
    return Operators[$urandom_range(0, 4)];
  endfunction

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DirectedItems; i++) begin
      pace();
      send_token(DirCmd[i], DirVal[i]);
    end
    wait_drained();

    for (int i = 0; i < RandomItems; i++) begin
      if (phase_left == 0) begin
        filling = !filling;
        phase_left = $urandom_range(10, 160);
      end
      phase_left--;
      if ($urandom_range(0, 99) == 0) wait_drained();
      pace();
      send_token(pick_command(filling), pick_operand());
    end

    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
